FILE: design/assert_macros.svh
// Shared assertion shorthands.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define PWSV_ASSERT(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
        else $error("%m: assertion failed");

// Antecedent at one edge implies consequent at the next.
`define PWSV_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

FILE: design/pwsv_pkg.sv
`default_nettype none

package pwsv_pkg;

    localparam int MAX_PERIOD  = 64;
    localparam int MAX_COUNT   = 64;
    localparam int SAMPLE_BITS = 16;

    localparam int DELAY_DEPTH = MAX_PERIOD * MAX_COUNT;
    localparam int PTR_W       = $clog2(DELAY_DEPTH);
    localparam int FILL_W      = PTR_W + 1;
    localparam int PHASE_W     = $clog2(MAX_PERIOD);
    localparam int CFG_W       = 7;
    localparam int OFFSET_W    = 16;
    localparam int SCALE_W     = 32;
    localparam int POS_W       = 20;
    localparam int STAT_W      = 40;
    localparam int SUM_W       = SAMPLE_BITS + 7;
    localparam int SQ_W        = 2 * SAMPLE_BITS + 5;
    localparam int SQR_W       = 2 * SAMPLE_BITS - 1;
    localparam int CS_W        = SQ_W + $clog2(MAX_COUNT);
    localparam int SS_W        = 2 * SUM_W - 1;
    localparam int D_W         = SS_W + 1;
    localparam int HI_W        = CS_W - SCALE_W;
    localparam int FRAC_SHIFT  = 24;
    localparam int V_W         = CS_W + SCALE_W - FRAC_SHIFT + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE    = 3'd4;

    localparam logic MODE_SUM   = 1'b0;
    localparam logic MODE_VAR   = 1'b1;
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_MAX = {1'b0, {(STAT_W-1){1'b1}}};

    typedef struct packed {
        logic                   clear;
        logic [SAMPLE_BITS-1:0] sample;
        logic [PHASE_W-1:0]     idx;
        logic [PTR_W-1:0]       rd;
        logic [PTR_W-1:0]       wp;
        logic                   sub;
        logic                   emit;
        logic [POS_W-1:0]       position;
    } pwsv_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } pwsv_q_status_t;

    function automatic logic [CFG_W-1:0] clamp_period(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0)
            r = CFG_W'(1);
        else if (v > CFG_W'(MAX_PERIOD))
            r = CFG_W'(MAX_PERIOD);
        return r;
    endfunction

    function automatic logic [CFG_W-1:0] clamp_count(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0)
            r = CFG_W'(1);
        else if (v > CFG_W'(MAX_COUNT))
            r = CFG_W'(MAX_COUNT);
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/pwsv_front.sv
`default_nettype none
`include "assert_macros.svh"

module pwsv_front
    import pwsv_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic                          cmd,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic [CFG_W-1:0]              period,
    input  wire logic [CFG_W-1:0]              window_count,
    input  wire logic [OFFSET_W-1:0]           start_offset,
    output pwsv_item_t                         item
);

    logic [PTR_W-1:0]   wp_reg;
    logic [PHASE_W-1:0] pc_reg;
    logic [POS_W-1:0]   index_reg;
    logic [FILL_W-1:0]  fill_reg;

    logic [CFG_W-1:0]    per_c;
    logic [CFG_W-1:0]    cnt_c;
    logic [2*CFG_W-1:0]  len_full;
    logic [FILL_W-1:0]   len_v;
    logic [FILL_W-1:0]   warm_v;
    logic [PHASE_W-1:0]  idx_v;
    logic [CFG_W-1:0]    idx_inc;
    logic [FILL_W:0]     fill_inc;
    logic [FILL_W-1:0]   fill_next;
    logic [PHASE_W-1:0]  pc_next;

    always_comb
    begin
        per_c    = clamp_period(period);
        cnt_c    = clamp_count(window_count);
        len_full = per_c * cnt_c;
        len_v    = len_full[FILL_W-1:0];
        warm_v   = len_v - FILL_W'(per_c);
        // a phase left over from a larger period restarts at zero
        idx_v    = (CFG_W'(pc_reg) >= per_c) ? '0 : pc_reg;
        idx_inc  = CFG_W'(idx_v) + CFG_W'(1);
        pc_next  = (idx_inc >= per_c) ? '0 : idx_inc[PHASE_W-1:0];
        fill_inc = (FILL_W+1)'(fill_reg) + (FILL_W+1)'(1);
        fill_next = (fill_inc >= (FILL_W+1)'(len_v)) ? len_v : fill_inc[FILL_W-1:0];

        item.clear    = (cmd == CMD_CLEAR);
        item.sample   = sample;
        item.idx      = idx_v;
        item.wp       = wp_reg;
        // full depth wraps to the write slot itself
        item.rd       = wp_reg - len_v[PTR_W-1:0];
        item.sub      = (fill_reg >= len_v);
        item.emit     = (fill_reg >= warm_v);
        item.position = index_reg + POS_W'(start_offset);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            pc_reg    <= '0;
            index_reg <= '0;
            fill_reg  <= '0;
        end
        else if (accept)
        begin
            if (cmd == CMD_CLEAR)
            begin
                wp_reg    <= '0;
                pc_reg    <= '0;
                index_reg <= '0;
                fill_reg  <= '0;
            end
            else
            begin
                wp_reg    <= wp_reg + PTR_W'(1);
                pc_reg    <= pc_next;
                index_reg <= index_reg + POS_W'(1);
                fill_reg  <= fill_next;
            end
        end
    end

    `PWSV_ASSERT(a_fill_bound, clk, rst_n, fill_reg <= FILL_W'(DELAY_DEPTH))

endmodule

`default_nettype wire

FILE: design/pwsv_queue.sv
`default_nettype none
`include "assert_macros.svh"

module pwsv_queue
    import pwsv_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire pwsv_item_t push_item,
    input  wire logic      pop,
    output pwsv_item_t     head,
    output pwsv_q_status_t status
);

    pwsv_item_t q_mem [QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head         = q_mem[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    `PWSV_ASSERT_NEXT(a_q_grow, clk, rst_n, push && !pop, count_reg == $past(count_reg) + QCNT_W'(1))

endmodule

`default_nettype wire

FILE: design/pwsv_back.sv
`default_nettype none
`include "assert_macros.svh"

module pwsv_back
    import pwsv_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire pwsv_q_status_t           q_status,
    input  wire pwsv_item_t               head,
    output logic                          pop,
    input  wire logic                     mode,
    input  wire logic [CFG_W-1:0]         window_count,
    input  wire logic [SCALE_W-1:0]       inv_scale,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [POS_W-1:0]              position,
    output logic signed [STAT_W-1:0]      stat_value
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_WB,
        S_MUL1,
        S_DIFF,
        S_MUL2,
        S_SAT,
        S_FIN
    } state_t;

    state_t state_reg;

    logic [SAMPLE_BITS-1:0] delay_mem [DELAY_DEPTH];
    logic [SUM_W-1:0]       sum_mem   [MAX_PERIOD];
    logic [SQ_W-1:0]        sq_mem    [MAX_PERIOD];

    logic [MAX_PERIOD-1:0]  sum_valid_reg;
    logic                   sum_ok_reg;
    logic                   out_valid_reg;
    logic [POS_W-1:0]       position_reg;
    logic [STAT_W-1:0]      stat_value_reg;

    pwsv_item_t             item_reg;
    logic [SAMPLE_BITS-1:0] old_raw_reg;
    logic [SUM_W-1:0]       sum_rd_reg;
    logic [SQ_W-1:0]        sq_rd_reg;
    logic signed [SAMPLE_BITS-1:0] old_reg;
    logic [SQR_W-1:0]       old_sq_reg;
    logic [SQR_W-1:0]       new_sq_reg;
    logic signed [SUM_W-1:0] sum_base_reg;
    logic [SQ_W-1:0]        sq_base_reg;
    logic signed [SUM_W-1:0] s1_reg;
    logic [SQ_W-1:0]        s2_reg;
    logic [CS_W-1:0]        cs_reg;
    logic [SS_W-1:0]        ss_reg;
    logic [CS_W-1:0]        d_reg;
    logic [CS_W-1:0]        hi_p_reg;
    logic [2*SCALE_W-1:0]   lo_p_reg;
    logic [STAT_W-1:0]      var_reg;

    logic                   rd_en;
    logic                   wb_en;
    logic                   out_free;
    logic [CFG_W-1:0]       cnt_c;
    logic signed [SAMPLE_BITS-1:0] old_s;
    logic signed [SAMPLE_BITS-1:0] new_s;
    logic signed [2*SAMPLE_BITS-1:0] old_sq_full;
    logic signed [2*SAMPLE_BITS-1:0] new_sq_full;
    logic signed [SUM_W-1:0] sum_next;
    logic [SQ_W-1:0]        sq_next;
    logic [CFG_W+SQ_W-1:0]  cs_full;
    logic signed [2*SUM_W-1:0] ss_full;
    logic signed [D_W-1:0]  diff;
    logic [HI_W-1:0]        d_hi;
    logic [CS_W-1:0]        hi_p_full;
    logic [2*SCALE_W-1:0]   lo_p_full;
    logic [V_W-1:0]         v_sum;
    logic [STAT_W-1:0]      var_next;
    logic [STAT_W-1:0]      fin_stat;
    logic                   var_path;

    always_comb
    begin
        pop      = (state_reg == S_IDLE) && !q_status.empty;
        rd_en    = pop && !head.clear;
        wb_en    = (state_reg == S_WB);
        out_free = !out_valid_reg || !out_stall;
        cnt_c    = clamp_count(window_count);
        var_path = (mode == MODE_VAR) && (cnt_c != CFG_W'(1));

        old_s       = old_raw_reg;
        new_s       = item_reg.sample;
        old_sq_full = old_s * old_s;
        new_sq_full = new_s * new_s;

        sum_next = sum_base_reg + SUM_W'(new_s)
                 - (item_reg.sub ? SUM_W'(old_reg) : SUM_W'(0));
        sq_next  = sq_base_reg + SQ_W'(new_sq_reg)
                 - (item_reg.sub ? SQ_W'(old_sq_reg) : SQ_W'(0));

        cs_full  = cnt_c * s2_reg;
        ss_full  = s1_reg * s1_reg;
        diff     = signed'(D_W'(cs_reg)) - signed'(D_W'(ss_reg));

        d_hi      = d_reg[CS_W-1:SCALE_W];
        hi_p_full = d_hi * inv_scale;
        lo_p_full = d_reg[SCALE_W-1:0] * inv_scale;

        v_sum    = V_W'({hi_p_reg, {(SCALE_W-FRAC_SHIFT){1'b0}}})
                 + V_W'(lo_p_reg[2*SCALE_W-1:FRAC_SHIFT]);
        var_next = (v_sum > V_W'(STAT_MAX)) ? STAT_MAX : v_sum[STAT_W-1:0];

        if (mode == MODE_SUM)
            fin_stat = STAT_W'(s1_reg);
        else if (cnt_c == CFG_W'(1))
            fin_stat = '0;
        else
            fin_stat = var_reg;
    end

    // delay line: read-before-write, so a full-depth window sees the old sample
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            old_raw_reg             <= delay_mem[head.rd];
            delay_mem[head.wp]      <= head.sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            sum_rd_reg <= sum_mem[head.idx];
            sq_rd_reg  <= sq_mem[head.idx];
        end
        if (wb_en)
        begin
            sum_mem[item_reg.idx] <= sum_next;
            sq_mem[item_reg.idx]  <= sq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                    item_reg <= head;
            end
            S_SQ:
            begin
                old_reg      <= old_s;
                old_sq_reg   <= old_sq_full[SQR_W-1:0];
                new_sq_reg   <= new_sq_full[SQR_W-1:0];
                sum_base_reg <= sum_ok_reg ? sum_rd_reg : '0;
                sq_base_reg  <= sum_ok_reg ? sq_rd_reg : '0;
            end
            S_WB:
            begin
                s1_reg <= sum_next;
                s2_reg <= sq_next;
            end
            S_MUL1:
            begin
                cs_reg <= cs_full[CS_W-1:0];
                ss_reg <= ss_full[SS_W-1:0];
            end
            S_DIFF:
            begin
                // non-positive numerator clamps to zero
                d_reg <= (!diff[D_W-1] && (diff != '0)) ? diff[CS_W-1:0] : '0;
            end
            S_MUL2:
            begin
                hi_p_reg <= hi_p_full;
                lo_p_reg <= lo_p_full;
            end
            S_SAT:
            begin
                var_reg <= var_next;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sum_valid_reg  <= '0;
            sum_ok_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            position_reg   <= '0;
            stat_value_reg <= '0;
        end
        else
        begin
            // in S_FIN the output register is handled by the state itself
            if (out_valid_reg && !out_stall && (state_reg != S_FIN))
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        if (head.clear)
                            sum_valid_reg <= '0;
                        else
                        begin
                            sum_ok_reg <= sum_valid_reg[head.idx];
                            state_reg  <= S_SQ;
                        end
                    end
                end
                S_SQ:
                begin
                    state_reg <= S_WB;
                end
                S_WB:
                begin
                    sum_valid_reg[item_reg.idx] <= 1'b1;
                    if (!item_reg.emit)
                        state_reg <= S_IDLE;
                    else if (var_path)
                        state_reg <= S_MUL1;
                    else
                        state_reg <= S_FIN;
                end
                S_MUL1:
                begin
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    state_reg <= S_SAT;
                end
                S_SAT:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        position_reg   <= item_reg.position;
                        stat_value_reg <= fin_stat;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign position   = position_reg;
    assign stat_value = stat_value_reg;

    `PWSV_ASSERT_NEXT(a_clear_wipes, clk, rst_n, pop && head.clear, sum_valid_reg == '0)
    `PWSV_ASSERT_NEXT(a_var_nonneg, clk, rst_n, state_reg == S_SAT, !var_reg[STAT_W-1])

endmodule

`default_nettype wire

FILE: design/periodic_window_sum_variance_core.sv
// Each input beat is queued; the back end then runs S_SQ and S_WB, and S_FIN in sum mode (or
// count 1); variance mode adds S_MUL1, S_DIFF, S_MUL2, S_SAT. A beat with no result ends at S_WB,
// a clear in idle; items pass one at a time through the single read-modify-write sequencer on the
// per-phase sum memories. A 4-entry queue lets the input side take beats while the back end is busy.
// Reset (rst_n, async, active low): registers to defaults, counters and queue empty,
// phase sums read as zero; the delay line is not cleared and needs no clearing pass.
`default_nettype none

module periodic_window_sum_variance_core
    import pwsv_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          cmd,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [POS_W-1:0]                   position,
    output logic signed [STAT_W-1:0]           stat_value
);

    logic [CFG_W-1:0]    period_reg;
    logic [CFG_W-1:0]    window_count_reg;
    logic [OFFSET_W-1:0] start_offset_reg;
    logic                mode_reg;
    logic [SCALE_W-1:0]  inv_scale_reg;

    logic           accept;
    logic           pop;
    pwsv_item_t     front_item;
    pwsv_item_t     head;
    pwsv_q_status_t q_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg       <= CFG_W'(1);
            window_count_reg <= CFG_W'(2);
            start_offset_reg <= '0;
            mode_reg         <= MODE_VAR;
            inv_scale_reg    <= {1'b1, {(SCALE_W-1){1'b0}}};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PERIOD:       period_reg       <= cfg_data[CFG_W-1:0];
                REG_WINDOW_COUNT: window_count_reg <= cfg_data[CFG_W-1:0];
                REG_START_OFFSET: start_offset_reg <= cfg_data[OFFSET_W-1:0];
                REG_MODE:         mode_reg         <= cfg_data[0];
                REG_INV_SCALE:    inv_scale_reg    <= cfg_data[SCALE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;

    pwsv_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .cmd          (cmd),
        .sample       (sample),
        .period       (period_reg),
        .window_count (window_count_reg),
        .start_offset (start_offset_reg),
        .item         (front_item)
    );

    pwsv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_item),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    pwsv_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .head         (head),
        .pop          (pop),
        .mode         (mode_reg),
        .window_count (window_count_reg),
        .inv_scale    (inv_scale_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .position     (position),
        .stat_value   (stat_value)
    );

endmodule

`default_nettype wire

FILE: verif/tb_periodic_window_sum_variance_core.sv
`timescale 1ns / 100ps

module tb_periodic_window_sum_variance_core
    import pwsv_pkg::*;
();

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_PHASE_BEATS = 250;
    localparam int WIDE_COUNT = 8;
    localparam longint unsigned STAT_LIMIT = (64'd1 << (STAT_W - 1)) - 64'd1;

    typedef struct {
        logic [POS_W-1:0]  pos;
        logic [STAT_W-1:0] stat;
    } window_stat_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          cmd = CMD_SAMPLE;
    logic signed [SAMPLE_BITS-1:0] sample = '0;
    logic                          out_stall = 1'b0;
    wire logic                     in_stall;
    wire logic                     out_valid;
    wire logic [POS_W-1:0]         position;
    wire logic signed [STAT_W-1:0] stat_value;

    periodic_window_sum_variance_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .position   (position),
        .stat_value (stat_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [SAMPLE_BITS-1:0] hist_mem [DELAY_DEPTH];
    logic [SUM_W-1:0]       acc_sum [MAX_PERIOD];
    logic [SQ_W-1:0]        acc_sq [MAX_PERIOD];
    logic [PTR_W-1:0]       hist_wr;
    int                     acc_phase;
    logic [POS_W-1:0]       beat_index;
    int                     fill_level;

    logic [CFG_W-1:0]    set_period = CFG_W'(1);
    logic [CFG_W-1:0]    set_count = CFG_W'(2);
    logic [OFFSET_W-1:0] set_offset = '0;
    logic                set_mode = MODE_VAR;
    logic [SCALE_W-1:0]  set_scale = 32'h8000_0000;

    window_stat_t expected_stats[$];

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int fail_count = 0;
    int beats_sent = 0;
    int results_checked = 0;
    int settings_used = 0;
    int cycle_count = 0;

    function automatic int clip_reg(input logic [CFG_W-1:0] v, input int hi);
        if (v == '0)
            return 1;
        if (int'(v) > hi)
            return hi;
        return int'(v);
    endfunction

    function automatic logic [SCALE_W-1:0] scale_for(input int c);
        longint unsigned n;
        if (c < 2)
            return SCALE_W'($urandom);
        n = longint'(c) * longint'(c - 1);
        return SCALE_W'((((64'd1 << 33) / n) + 64'd1) >> 1);
    endfunction

    function automatic void restart_series();
        for (int p = 0; p < MAX_PERIOD; p++)
        begin
            acc_sum[p] = '0;
            acc_sq[p] = '0;
        end
        hist_wr = '0;
        acc_phase = 0;
        beat_index = '0;
        fill_level = 0;
    endfunction

    function automatic void predict_beat(input logic c, input logic signed [SAMPLE_BITS-1:0] s);
        int per, cnt, len, warm, ph, fill_before;
        logic [PTR_W-1:0] rd;
        longint sv, old, s1, num;
        longint unsigned unum, hi, lo, v;
        window_stat_t r;
        if (c == CMD_CLEAR)
        begin
            restart_series();
            return;
        end
        per = clip_reg(set_period, MAX_PERIOD);
        cnt = clip_reg(set_count, MAX_COUNT);
        len = cnt * per;
        warm = (cnt - 1) * per;
        ph = (acc_phase >= per) ? 0 : acc_phase;
        fill_before = fill_level;
        rd = hist_wr - PTR_W'(len);
        sv = s;
        acc_sum[ph] = acc_sum[ph] + SUM_W'(sv);
        acc_sq[ph] = acc_sq[ph] + SQ_W'(sv * sv);
        // oldest sample of this phase leaves the window
        if (fill_before >= len)
        begin
            old = longint'($signed(hist_mem[rd]));
            acc_sum[ph] = acc_sum[ph] - SUM_W'(old);
            acc_sq[ph] = acc_sq[ph] - SQ_W'(old * old);
        end
        hist_mem[hist_wr] = s;
        hist_wr = hist_wr + 1'b1;
        fill_level = (fill_before + 1 >= len) ? len : fill_before + 1;
        acc_phase = (ph + 1 >= per) ? 0 : ph + 1;
        if (fill_before >= warm)
        begin
            s1 = longint'($signed(acc_sum[ph]));
            if (set_mode == MODE_SUM)
                r.stat = STAT_W'(s1);
            else if (cnt == 1)
                r.stat = '0;
            else
            begin
                num = longint'(cnt) * longint'(acc_sq[ph]) - s1 * s1;
                if (num <= 0)
                    r.stat = '0;
                else
                begin
                    unum = num;
                    hi = unum >> 32;
                    lo = unum & 64'hFFFF_FFFF;
                    v = ((hi * set_scale) << 8) + ((lo * set_scale) >> 24);
                    r.stat = (v > STAT_LIMIT) ? STAT_W'(STAT_LIMIT) : STAT_W'(v);
                end
            end
            r.pos = beat_index + POS_W'(set_offset);
            expected_stats.push_back(r);
        end
        beat_index = beat_index + 1'b1;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return SAMPLE_BITS'(int'($urandom_range(200)) - 100);
            3: return '0;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // receiving side: check each accepted result, then pick next stall
    always @(posedge clk)
    begin
        window_stat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_stats.size() == 0)
            begin
                $display("%0t unexpected result: expected none, got position %0d stat %0d",
                         $time, position, stat_value);
                fail_count++;
            end
            else
            begin
                want = expected_stats.pop_front();
                if (position !== want.pos)
                begin
                    $display("%0t position mismatch: expected %0d, got %0d",
                             $time, want.pos, position);
                    fail_count++;
                end
                if (stat_value !== want.stat)
                begin
                    $display("%0t stat_value mismatch: expected %0d, got %0d",
                             $time, $signed(want.stat), stat_value);
                    fail_count++;
                end
                results_checked++;
            end
        end
        out_stall <= (hold_left != 0) || ($urandom_range(99) < sink_idle_pct);
    end

    // long receiver hold-off, started by bumping hold_req
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_beat(input logic c, input logic signed [SAMPLE_BITS-1:0] s);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        sample <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_beat(c, s);
        beats_sent++;
    endtask

    task automatic stream_samples(input int n, input int clear_pct);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < clear_pct)
                send_beat(CMD_CLEAR, SAMPLE_BITS'($urandom));
            else
                send_beat(CMD_SAMPLE, random_sample());
        end
    endtask

    // drop valid, wait for all results, then let beats with no result drain
    task automatic await_results();
        in_valid <= 1'b0;
        while (expected_stats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value, input int w);
        // junk above the register width must be ignored
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= ((CFG_DATA_W'($urandom) >> w) << w) | value;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] p, input logic [CFG_W-1:0] c,
                                  input logic [OFFSET_W-1:0] o, input logic m,
                                  input logic [SCALE_W-1:0] sc);
        write_reg(REG_PERIOD, CFG_DATA_W'(p), CFG_W);
        write_reg(REG_WINDOW_COUNT, CFG_DATA_W'(c), CFG_W);
        write_reg(REG_START_OFFSET, CFG_DATA_W'(o), OFFSET_W);
        write_reg(REG_MODE, CFG_DATA_W'(m), 1);
        write_reg(REG_INV_SCALE, CFG_DATA_W'(sc), SCALE_W);
        cfg_we <= 1'b0;
        set_period = p;
        set_count = c;
        set_offset = o;
        set_mode = m;
        set_scale = sc;
        settings_used++;
    endtask

    task automatic apply_random_settings();
        logic [CFG_W-1:0] p, c;
        logic [OFFSET_W-1:0] o;
        logic [SCALE_W-1:0] sc;
        case ($urandom_range(9))
            0:
            begin
                p = CFG_W'($urandom_range(9, 64));
                c = CFG_W'($urandom_range(1, 2));
            end
            1:
            begin
                p = CFG_W'($urandom_range(1, 2));
                c = CFG_W'($urandom_range(32, 64));
            end
            2:
            begin
                p = ($urandom_range(1) != 0) ? CFG_W'(0) : CFG_W'($urandom_range(65, 127));
                c = ($urandom_range(1) != 0) ? CFG_W'(0) : CFG_W'($urandom_range(2, 3));
            end
            3:
            begin
                p = CFG_W'($urandom_range(1));
                c = CFG_W'($urandom_range(65, 127));
            end
            default:
            begin
                p = CFG_W'($urandom_range(1, 8));
                c = CFG_W'($urandom_range(1, 8));
            end
        endcase
        case ($urandom_range(9))
            0: sc = '0;
            1: sc = '1;
            2: sc = SCALE_W'($urandom);
            default: sc = scale_for(clip_reg(c, MAX_COUNT));
        endcase
        case ($urandom_range(5))
            0: o = '0;
            1: o = '1;
            default: o = OFFSET_W'($urandom);
        endcase
        apply_settings(p, c, o, ($urandom_range(1) != 0) ? MODE_VAR : MODE_SUM, sc);
    endtask

    // values straight after reset, no register written yet
    task automatic test_reset_defaults();
        send_beat(CMD_SAMPLE, 16'sh7FFF);
        send_beat(CMD_SAMPLE, 16'sh8000);
        send_beat(CMD_SAMPLE, 16'sh0000);
        send_beat(CMD_SAMPLE, -16'sd1);
        send_beat(CMD_SAMPLE, 16'sd1);
        await_results();
    endtask

    task automatic test_variance_saturation();
        apply_settings(CFG_W'(1), CFG_W'(2), '0, MODE_VAR, '1);
        send_beat(CMD_CLEAR, 16'sh7FFF);
        send_beat(CMD_SAMPLE, 16'sh7FFF);
        send_beat(CMD_SAMPLE, 16'sh8000);
        send_beat(CMD_SAMPLE, 16'sh7FFF);
        await_results();
    endtask

    task automatic test_count_one();
        apply_settings(CFG_W'(1), CFG_W'(1), '1, MODE_SUM, '0);
        send_beat(CMD_CLEAR, '0);
        send_beat(CMD_SAMPLE, 16'sh8000);
        send_beat(CMD_SAMPLE, 16'sh7FFF);
        await_results();
        apply_settings(CFG_W'(1), CFG_W'(1), '0, MODE_VAR, 32'h1234_5678);
        send_beat(CMD_CLEAR, '0);
        send_beat(CMD_SAMPLE, 16'sd500);
        await_results();
    endtask

    // period above range saturates to the maximum, count zero acts as one
    task automatic test_out_of_range();
        apply_settings(CFG_W'(127), CFG_W'(0), 16'd7, MODE_SUM, '0);
        send_beat(CMD_CLEAR, '0);
        send_beat(CMD_SAMPLE, 16'sd1);
        send_beat(CMD_SAMPLE, -16'sd2);
        send_beat(CMD_SAMPLE, 16'sd3);
        await_results();
    endtask

    // count shrinks without a clear: kept sums give a negative numerator
    task automatic test_negative_numerator();
        apply_settings(CFG_W'(1), CFG_W'(3), '0, MODE_VAR, scale_for(3));
        send_beat(CMD_CLEAR, '0);
        send_beat(CMD_SAMPLE, 16'sd10);
        send_beat(CMD_SAMPLE, 16'sd10);
        send_beat(CMD_SAMPLE, 16'sd10);
        send_beat(CMD_SAMPLE, 16'sd100);
        await_results();
        apply_settings(CFG_W'(1), CFG_W'(2), '0, MODE_VAR, scale_for(2));
        send_beat(CMD_SAMPLE, 16'sd100);
        await_results();
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        sink_idle_pct <= 0;
        apply_settings(CFG_W'(2), CFG_W'(4), 16'd100, MODE_VAR, scale_for(4));
        send_beat(CMD_CLEAR, '0);
        hold_req <= hold_req + 1;
        stream_samples(80, 0);
        await_results();
        sink_idle_pct <= 30;
        stream_samples(30, 0);
        await_results();
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct);
        int sent, n;
        src_idle_pct = src_pct;
        sink_idle_pct <= sink_pct;
        sent = 0;
        while (sent < RANDOM_PHASE_BEATS)
        begin
            await_results();
            apply_random_settings();
            send_beat(CMD_CLEAR, SAMPLE_BITS'($urandom));
            n = (clip_reg(set_count, MAX_COUNT) - 1) * clip_reg(set_period, MAX_PERIOD)
                + $urandom_range(8, 48);
            stream_samples(n, 2);
            sent += n + 1;
            // new registers on top of the running sums
            if ($urandom_range(4) == 0)
            begin
                await_results();
                apply_random_settings();
                n = $urandom_range(10, 30);
                stream_samples(n, 0);
                sent += n;
            end
        end
        await_results();
    endtask

    // period at its maximum, every phase leaves its window
    task automatic test_widest_period();
        src_idle_pct = 0;
        sink_idle_pct <= 0;
        apply_settings(CFG_W'(MAX_PERIOD), CFG_W'(WIDE_COUNT), 16'd1, MODE_VAR,
                       scale_for(WIDE_COUNT));
        send_beat(CMD_CLEAR, '0);
        stream_samples(MAX_PERIOD * WIDE_COUNT + 100, 0);
        await_results();
    endtask

    initial
    begin
        restart_series();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_variance_saturation();
        test_count_one();
        test_out_of_range();
        test_negative_numerator();
        test_backpressure();
        test_random_traffic(10, 55);
        test_random_traffic(55, 10);
        test_random_traffic(0, 0);
        test_widest_period();

        await_results();
        $display("%0d beats sent, %0d window results checked, %0d register settings",
                 beats_sent, results_checked, settings_used);
        $display("covered clears, count one, clamped registers, saturation, hold-off, max period");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
